// ===== src/bb3_pkg.sv =====
`default_nettype none

package bb3_pkg;

    // frame geometry
    localparam int MAX_WIDTH = 2048;
    localparam int MIN_DIM   = 3;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int CFG_W     = 12;
    localparam int PIX_W     = 8;

    // configuration registers
    localparam int CFG_INDEX_W   = 1;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // nine-tap sum and floor(sum / 9) as (sum * 1821) >> 14, exact for sum <= 2295
    localparam int SUM_W      = 12;
    localparam int DIV9_MUL   = 1821;
    localparam int DIV9_SHIFT = 14;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             last;
    } result_t;

    // control of the item held between input register and result queue
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             last;
        logic [COL_W-1:0] addr;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
    } stage_t;

endpackage

`default_nettype wire

// ===== src/bb3_pix_if.sv =====
`default_nettype none

interface bb3_pix_if;
    logic                      valid;
    logic                      ready;
    logic [bb3_pkg::PIX_W-1:0] in_red;
    logic [bb3_pkg::PIX_W-1:0] in_green;
    logic [bb3_pkg::PIX_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

`default_nettype wire

// ===== src/bb3_res_if.sv =====
`default_nettype none

interface bb3_res_if;
    logic                      valid;
    logic                      ready;
    logic [bb3_pkg::PIX_W-1:0] out_red;
    logic [bb3_pkg::PIX_W-1:0] out_green;
    logic [bb3_pkg::PIX_W-1:0] out_blue;
    logic [bb3_pkg::ROW_W-1:0] out_row;
    logic [bb3_pkg::COL_W-1:0] out_column;
    logic                      out_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output out_row, output out_column, output out_last, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input out_row, input out_column, input out_last, output ready);
endinterface

`default_nettype wire

// ===== src/bb3_line_store.sv =====
`default_nettype none

module bb3_line_store (
    input  wire logic                      clk,
    input  wire logic                      rd_en,
    input  wire logic [bb3_pkg::COL_W-1:0] rd_addr,
    input  wire logic                      wr_en,
    input  wire logic [bb3_pkg::COL_W-1:0] wr_addr,
    input  wire bb3_pkg::pixel_t           wr_pixel,
    output bb3_pkg::pixel_t                up,
    output bb3_pkg::pixel_t                mid
);

    bb3_pkg::pixel_t upper_mem [bb3_pkg::MAX_WIDTH];
    bb3_pkg::pixel_t lower_mem [bb3_pkg::MAX_WIDTH];
    bb3_pkg::pixel_t up_reg;
    bb3_pkg::pixel_t mid_reg;

    // the lower row moves up and the incoming pixel takes its place
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr] <= mid_reg;
            lower_mem[wr_addr] <= wr_pixel;
        end
        if (rd_en)
        begin
            up_reg  <= upper_mem[rd_addr];
            mid_reg <= lower_mem[rd_addr];
        end
    end

    assign up  = up_reg;
    assign mid = mid_reg;

endmodule

`default_nettype wire

// ===== src/bb3_window.sv =====
`default_nettype none

module bb3_window (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift,
    input  wire bb3_pkg::pixel_t up,
    input  wire bb3_pkg::pixel_t mid,
    input  wire bb3_pkg::pixel_t cur,
    output bb3_pkg::pixel_t      blurred
);

    // [0] top, [1] middle, [2] bottom
    bb3_pkg::pixel_t col1_reg [3];
    bb3_pkg::pixel_t col2_reg [3];

    function automatic logic [bb3_pkg::SUM_W-1:0] sum9(
        input logic [bb3_pkg::PIX_W-1:0] t0, input logic [bb3_pkg::PIX_W-1:0] t1,
        input logic [bb3_pkg::PIX_W-1:0] t2, input logic [bb3_pkg::PIX_W-1:0] t3,
        input logic [bb3_pkg::PIX_W-1:0] t4, input logic [bb3_pkg::PIX_W-1:0] t5,
        input logic [bb3_pkg::PIX_W-1:0] t6, input logic [bb3_pkg::PIX_W-1:0] t7,
        input logic [bb3_pkg::PIX_W-1:0] t8);
        logic [bb3_pkg::SUM_W-1:0] a;
        logic [bb3_pkg::SUM_W-1:0] b;
        a = (bb3_pkg::SUM_W'(t0) + bb3_pkg::SUM_W'(t1))
          + (bb3_pkg::SUM_W'(t2) + bb3_pkg::SUM_W'(t3));
        b = (bb3_pkg::SUM_W'(t4) + bb3_pkg::SUM_W'(t5))
          + (bb3_pkg::SUM_W'(t6) + bb3_pkg::SUM_W'(t7));
        return a + b + bb3_pkg::SUM_W'(t8);
    endfunction

    function automatic logic [bb3_pkg::PIX_W-1:0] div9(
        input logic [bb3_pkg::SUM_W-1:0] s);
        logic [bb3_pkg::SUM_W+bb3_pkg::DIV9_SHIFT-1:0] prod;
        prod = (bb3_pkg::SUM_W + bb3_pkg::DIV9_SHIFT)'(s)
             * (bb3_pkg::SUM_W + bb3_pkg::DIV9_SHIFT)'(bb3_pkg::DIV9_MUL);
        return prod[bb3_pkg::DIV9_SHIFT +: bb3_pkg::PIX_W];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                col1_reg[i] <= '0;
                col2_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            for (int i = 0; i < 3; i++)
            begin
                col2_reg[i] <= col1_reg[i];
            end
            col1_reg[0] <= up;
            col1_reg[1] <= mid;
            col1_reg[2] <= cur;
        end
    end

    always_comb
    begin
        blurred.red = div9(sum9(col2_reg[0].red, col2_reg[1].red, col2_reg[2].red,
                                col1_reg[0].red, col1_reg[1].red, col1_reg[2].red,
                                up.red, mid.red, cur.red));
        blurred.green = div9(sum9(col2_reg[0].green, col2_reg[1].green, col2_reg[2].green,
                                  col1_reg[0].green, col1_reg[1].green, col1_reg[2].green,
                                  up.green, mid.green, cur.green));
        blurred.blue = div9(sum9(col2_reg[0].blue, col2_reg[1].blue, col2_reg[2].blue,
                                 col1_reg[0].blue, col1_reg[1].blue, col1_reg[2].blue,
                                 up.blue, mid.blue, cur.blue));
    end

endmodule

`default_nettype wire

// ===== src/bb3_out_queue.sv =====
`default_nettype none

module bb3_out_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire bb3_pkg::result_t push_data,
    input  wire logic             pending,
    output logic                  room,
    bb3_res_if.source             results
);

    bb3_pkg::result_t               entry_reg [bb3_pkg::QUEUE_DEPTH];
    logic [bb3_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [bb3_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [bb3_pkg::QCNT_W-1:0]     count_reg;
    logic [bb3_pkg::QCNT_W-1:0]     count_next;
    logic                           pop;
    bb3_pkg::result_t               head;

    assign pop = results.valid && results.ready;

    // one new item plus the one in flight must still fit
    assign room = (count_reg + bb3_pkg::QCNT_W'(pending))
                  <= bb3_pkg::QCNT_W'(bb3_pkg::QUEUE_DEPTH - 1);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head              = entry_reg[rd_ptr_reg];
    assign results.valid      = (count_reg != '0);
    assign results.out_red    = head.red;
    assign results.out_green  = head.green;
    assign results.out_blue   = head.blue;
    assign results.out_row    = head.row;
    assign results.out_column = head.column;
    assign results.out_last   = head.last;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != bb3_pkg::QCNT_W'(bb3_pkg::QUEUE_DEPTH)))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bb3_pkg::QCNT_W'(bb3_pkg::QUEUE_DEPTH))
        else $error("result queue count out of range");

    a_no_room_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == bb3_pkg::QCNT_W'(bb3_pkg::QUEUE_DEPTH - 1) && pending) |-> !room)
        else $error("queue offers room it cannot hold");
`endif

endmodule

`default_nettype wire

// ===== src/rgb_box_blur_3x3.sv =====
`default_nettype none

// channel   direction  handshake      payload
// pixels    in         valid/ready    in_red, in_green, in_blue (8b each)
// results   out        valid/ready    out_red/green/blue (8b), out_row (12b),
//                                     out_column (11b), out_last (1b)
// cfg       in         cfg_we         cfg_index (0 width, 1 height), cfg_data (12b)
//
// one pixel transfer per clock sustained while the result queue has room; the
// line store pair does one read at pixel acceptance and one write in the
// following cycle, which sets the rate; a result is pushed into the queue in the
// cycle after the pixel transfer that completes its window
// rst_n clears counters, window and queue; line stores keep no reset state
// a stalled results channel drops pixels.ready once three results wait in the
// four-entry queue with a fourth on its way, or the queue is full

module rgb_box_blur_3x3 (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bb3_pkg::CFG_W-1:0]       cfg_data,
    bb3_pix_if.sink                              pixels,
    bb3_res_if.source                            results
);

    logic [bb3_pkg::CFG_W-1:0] image_width_reg;
    logic [bb3_pkg::CFG_W-1:0] image_height_reg;
    logic [bb3_pkg::COL_W-1:0] w_last;
    logic [bb3_pkg::ROW_W-1:0] h_last;

    logic [bb3_pkg::COL_W-1:0] column_reg;
    logic [bb3_pkg::COL_W-1:0] column_next;
    logic [bb3_pkg::ROW_W-1:0] row_reg;
    logic [bb3_pkg::ROW_W-1:0] row_next;

    bb3_pkg::stage_t           stage_reg;
    bb3_pkg::stage_t           stage_next;
    bb3_pkg::pixel_t           cur_reg;
    bb3_pkg::pixel_t           in_pixel;

    bb3_pkg::pixel_t           up;
    bb3_pkg::pixel_t           mid;
    bb3_pkg::pixel_t           blurred;
    bb3_pkg::result_t          result;

    logic                      accept;
    logic                      room;
    logic                      row_end;
    logic                      frame_end;
    logic                      push;

    // configuration, to be written only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bb3_pkg::CFG_W'(bb3_pkg::WIDTH_RESET);
            image_height_reg <= bb3_pkg::CFG_W'(bb3_pkg::HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            case (bb3_pkg::cfg_reg_t'(cfg_index))
                bb3_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                bb3_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // last column and row index, after clamping to the legal frame size
    always_comb
    begin
        if (image_width_reg < bb3_pkg::CFG_W'(bb3_pkg::MIN_DIM))
        begin
            w_last = bb3_pkg::COL_W'(bb3_pkg::MIN_DIM - 1);
        end
        else if (image_width_reg > bb3_pkg::CFG_W'(bb3_pkg::MAX_WIDTH))
        begin
            w_last = bb3_pkg::COL_W'(bb3_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            w_last = bb3_pkg::COL_W'(image_width_reg - 1'b1);
        end

        if (image_height_reg < bb3_pkg::CFG_W'(bb3_pkg::MIN_DIM))
        begin
            h_last = bb3_pkg::ROW_W'(bb3_pkg::MIN_DIM - 1);
        end
        else
        begin
            h_last = bb3_pkg::ROW_W'(image_height_reg - 1'b1);
        end
    end

    assign accept       = pixels.valid && pixels.ready;
    assign pixels.ready = room;

    assign row_end   = (column_reg >= w_last);
    assign frame_end = (row_reg >= h_last);

    // raster position of the next incoming pixel
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                column_next = '0;
                row_next    = frame_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                column_next = column_reg + 1'b1;
            end
        end
    end

    // input register: control for the item whose line store read is in flight
    always_comb
    begin
        stage_next.valid  = accept;
        stage_next.emit   = (row_reg >= bb3_pkg::ROW_W'(2))
                            && (column_reg >= bb3_pkg::COL_W'(2));
        stage_next.last   = row_end && frame_end;
        stage_next.addr   = column_reg;
        stage_next.row    = row_reg - 1'b1;
        stage_next.column = column_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            stage_reg  <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            stage_reg  <= stage_next;
        end
    end

    assign in_pixel.red   = pixels.in_red;
    assign in_pixel.green = pixels.in_green;
    assign in_pixel.blue  = pixels.in_blue;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg <= in_pixel;
        end
    end

    // read at acceptance, written back next cycle; neighbors never share a column
    bb3_line_store u_line_store (
        .clk      (clk),
        .rd_en    (accept),
        .rd_addr  (column_reg),
        .wr_en    (stage_reg.valid),
        .wr_addr  (stage_reg.addr),
        .wr_pixel (cur_reg),
        .up       (up),
        .mid      (mid)
    );

    bb3_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (stage_reg.valid),
        .up      (up),
        .mid     (mid),
        .cur     (cur_reg),
        .blurred (blurred)
    );

    // the staged item never stalls; the queue absorbs result back-pressure
    assign push          = stage_reg.valid && stage_reg.emit;
    assign result.red    = blurred.red;
    assign result.green  = blurred.green;
    assign result.blue   = blurred.blue;
    assign result.row    = stage_reg.row;
    assign result.column = stage_reg.column;
    assign result.last   = stage_reg.last;

    bb3_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .pending   (push),
        .room      (room),
        .results   (results)
    );

`ifndef SYNTH
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_end && frame_end) |=> (row_reg == '0 && column_reg == '0))
        else $error("counters did not wrap at end of frame");

    a_emit_interior: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (stage_reg.row != '0 && stage_reg.column != '0))
        else $error("result emitted for a border pixel");

    a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        stage_reg.valid |-> $past(accept))
        else $error("staged item without a pixel transfer");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

    // cycles without any transfer before the run is given up
    localparam int QUIET_LIMIT   = 2000;
    // block latency plus result queue depth, with margin
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 1000;
    // widest row the random geometry uses
    localparam int FILL_WIDTH    = 64;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    bb3_pkg::cfg_reg_t          cfg_index;
    logic [bb3_pkg::CFG_W-1:0]  cfg_data;

    bb3_pix_if pix_ch ();
    bb3_res_if res_ch ();

    rgb_box_blur_3x3 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_ch),
        .results   (res_ch)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // blur predictor: own copy of geometry, line stores, window, position
    // ------------------------------------------------------------------

    // register values as written, raw and unclamped
    int unsigned frame_width  = bb3_pkg::WIDTH_RESET;
    int unsigned frame_height = bb3_pkg::HEIGHT_RESET;

    // rows r-2 and r-1 at each column, entries keep their content across frames
    bb3_pkg::pixel_t upper_line [bb3_pkg::MAX_WIDTH];
    bb3_pkg::pixel_t lower_line [bb3_pkg::MAX_WIDTH];
    // window columns c-1 and c-2, index 0 top, 1 middle, 2 bottom
    bb3_pkg::pixel_t win_prev  [3] = '{default: '0};
    bb3_pkg::pixel_t win_prev2 [3] = '{default: '0};
    // position of the next incoming pixel
    logic [bb3_pkg::COL_W-1:0] next_col = '0;
    logic [bb3_pkg::ROW_W-1:0] next_row = '0;

    bb3_pkg::pixel_t  pending_pixels [$];
    bb3_pkg::result_t blur_expected  [$];

    int  err_count    = 0;
    int  quiet_cycles = 0;
    int  send_gap     = 0;
    int  stall_left   = 0;
    // no idling on either side once set
    bit  calm         = 1'b0;

    // register values out of range act as the nearest legal size
    function automatic int unsigned effective_width();
        int unsigned w = frame_width;
        if (w < bb3_pkg::MIN_DIM)
            w = bb3_pkg::MIN_DIM;
        if (w > bb3_pkg::MAX_WIDTH)
            w = bb3_pkg::MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned effective_height();
        int unsigned h = frame_height;
        if (h < bb3_pkg::MIN_DIM)
            h = bb3_pkg::MIN_DIM;
        return h;
    endfunction

    // one accepted pixel: update stores and window, queue the blur it completes
    function automatic void blur_accept(bb3_pkg::pixel_t px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      sum_r;
        int unsigned      sum_g;
        int unsigned      sum_b;
        bb3_pkg::pixel_t  up;
        bb3_pkg::pixel_t  mid;
        bb3_pkg::result_t res;
        w   = effective_width();
        h   = effective_height();
        up  = upper_line[next_col];
        mid = lower_line[next_col];
        upper_line[next_col] = mid;
        lower_line[next_col] = px;

        // the window is full from the third column of the third row on
        if (next_row >= 2 && next_col >= 2)
        begin
            sum_r = 32'(up.red)   + 32'(mid.red)   + 32'(px.red);
            sum_g = 32'(up.green) + 32'(mid.green) + 32'(px.green);
            sum_b = 32'(up.blue)  + 32'(mid.blue)  + 32'(px.blue);
            for (int k = 0; k < 3; k++)
            begin
                sum_r += 32'(win_prev[k].red)   + 32'(win_prev2[k].red);
                sum_g += 32'(win_prev[k].green) + 32'(win_prev2[k].green);
                sum_b += 32'(win_prev[k].blue)  + 32'(win_prev2[k].blue);
            end
            res.red    = bb3_pkg::PIX_W'(sum_r / 9);
            res.green  = bb3_pkg::PIX_W'(sum_g / 9);
            res.blue   = bb3_pkg::PIX_W'(sum_b / 9);
            res.row    = bb3_pkg::ROW_W'(next_row - 1'b1);
            res.column = bb3_pkg::COL_W'(next_col - 1'b1);
            res.last   = (32'(next_row) >= h - 1) && (32'(next_col) >= w - 1);
            blur_expected.push_back(res);
        end

        win_prev2 = win_prev;
        win_prev  = '{up, mid, px};

        // row and frame ends follow the geometry in force right now
        if (32'(next_col) >= w - 1)
        begin
            next_col = '0;
            if (32'(next_row) >= h - 1)
                next_row = '0;
            else
                next_row = next_row + 1'b1;
        end
        else
        begin
            next_col = next_col + 1'b1;
        end
    endfunction

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            err_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // pixel driver: sends from pending_pixels, random gap bursts
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        bb3_pkg::pixel_t nxt;
        if (!rst_n)
        begin
            pix_ch.valid    <= 1'b0;
            pix_ch.in_red   <= '0;
            pix_ch.in_green <= '0;
            pix_ch.in_blue  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
                blur_accept('{pix_ch.in_red, pix_ch.in_green, pix_ch.in_blue});

            // a held pixel stays on the bus until its transfer
            if (!pix_ch.valid || pix_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pix_ch.valid <= 1'b0;
                end
                else if (pending_pixels.size() == 0)
                begin
                    pix_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 19) == 0)
                begin
                    // this cycle is the first of the burst
                    send_gap = $urandom_range(0, 14);
                    pix_ch.valid <= 1'b0;
                end
                else
                begin
                    nxt = pending_pixels.pop_front();
                    pix_ch.in_red   <= nxt.red;
                    pix_ch.in_green <= nxt.green;
                    pix_ch.in_blue  <= nxt.blue;
                    pix_ch.valid    <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random stall bursts, in-order compare
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        bb3_pkg::result_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (blur_expected.size() == 0)
                begin
                    $error("result at row %0d column %0d with nothing expected",
                           res_ch.out_row, res_ch.out_column);
                    err_count++;
                end
                else
                begin
                    want = blur_expected.pop_front();
                    check_field("out_red",    16'(want.red),    16'(res_ch.out_red));
                    check_field("out_green",  16'(want.green),  16'(res_ch.out_green));
                    check_field("out_blue",   16'(want.blue),   16'(res_ch.out_blue));
                    check_field("out_row",    16'(want.row),    16'(res_ch.out_row));
                    check_field("out_column", 16'(want.column), 16'(res_ch.out_column));
                    check_field("out_last",   16'(want.last),   16'(res_ch.out_last));
                end
            end

            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends a run that stops making transfers
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // register write while the block is idle; predictor copy follows
    task automatic set_reg(bb3_pkg::cfg_reg_t idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[bb3_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == bb3_pkg::REG_IMAGE_WIDTH)
            frame_width = val;
        else
            frame_height = val;
        @(negedge clk);
    endtask

    // sender holds off until every blur in flight has come back,
    // then the block gets time to finish work that yields no result
    task automatic settle();
        while (pending_pixels.size() != 0 || pix_ch.valid || blur_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly random, some pixels at the rails so sums reach 0 and 2295
    function automatic bb3_pkg::pixel_t random_pixel();
        logic [31:0] word;
        word = $urandom;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return word[23:0];
        endcase
    endfunction

    initial
    begin : stimulus
        int unsigned random_sent;
        int unsigned count;
        int unsigned roll;
        int unsigned w;
        int unsigned h;
        logic [31:0] mix;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= bb3_pkg::REG_IMAGE_WIDTH;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // smallest frame, all white then all black, back to back
        set_reg(bb3_pkg::REG_IMAGE_WIDTH, 3);
        set_reg(bb3_pkg::REG_IMAGE_HEIGHT, 3);
        repeat (9) pending_pixels.push_back('1);
        repeat (9) pending_pixels.push_back('0);
        settle();

        // undersized registers act as 3; channels at 0 or 255 exercise the floor
        set_reg(bb3_pkg::REG_IMAGE_WIDTH, 0);
        set_reg(bb3_pkg::REG_IMAGE_HEIGHT, 2);
        repeat (9)
        begin
            mix = $urandom;
            pending_pixels.push_back({{8{mix[0]}}, {8{mix[1]}}, {8{mix[2]}}});
        end
        settle();

        // a full frame at the widest random row fills every line store column
        // that later width changes can reach
        set_reg(bb3_pkg::REG_IMAGE_WIDTH, FILL_WIDTH);
        set_reg(bb3_pkg::REG_IMAGE_HEIGHT, 3);
        repeat (3 * FILL_WIDTH) pending_pixels.push_back(random_pixel());
        settle();

        // height cut below the current row mid-frame: frame closes at row end
        set_reg(bb3_pkg::REG_IMAGE_WIDTH, 8);
        set_reg(bb3_pkg::REG_IMAGE_HEIGHT, 20);
        repeat (8 * 6 + 3) pending_pixels.push_back(random_pixel());
        settle();
        set_reg(bb3_pkg::REG_IMAGE_HEIGHT, 4);
        repeat (5 + 8 * 2 + 5) pending_pixels.push_back(random_pixel());
        settle();

        // width cut below the current column mid-row: row closes on next pixel
        set_reg(bb3_pkg::REG_IMAGE_WIDTH, 4);
        repeat (1 + 4 + 4 * 2 + 1) pending_pixels.push_back(random_pixel());
        settle();

        // width raised mid-row: wider columns come from older rows in the stores
        set_reg(bb3_pkg::REG_IMAGE_WIDTH, 12);
        repeat (11 + 12) pending_pixels.push_back(random_pixel());
        settle();

        // random geometry and content, mostly whole frames streamed back to back,
        // some cut short so that register changes also land mid-frame
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent > RANDOM_ITEMS * 4 / 5)
                calm = 1'b1;

            if ($urandom_range(0, 3) != 0)
            begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    set_reg(bb3_pkg::REG_IMAGE_WIDTH, $urandom_range(0, 2));
                else if (roll < 5)
                    set_reg(bb3_pkg::REG_IMAGE_WIDTH, $urandom_range(17, FILL_WIDTH));
                else
                    set_reg(bb3_pkg::REG_IMAGE_WIDTH, $urandom_range(3, 16));
            end
            if ($urandom_range(0, 3) != 0)
            begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    set_reg(bb3_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, 2));
                else if (roll == 1)
                    set_reg(bb3_pkg::REG_IMAGE_HEIGHT, $urandom_range(17, 4095));
                else
                    set_reg(bb3_pkg::REG_IMAGE_HEIGHT, $urandom_range(3, 10));
            end

            w = effective_width();
            h = effective_height();
            // tall settings only ever see a few rows before the next change
            if (h > 16 || $urandom_range(0, 4) == 0)
                count = $urandom_range(1, 4 * w);
            else
                count = $urandom_range(1, 3) * w * h;

            repeat (count) pending_pixels.push_back(random_pixel());
            random_sent += count;
            settle();
        end

        // settle above already drained everything; leave time for stray output
        repeat (2 * SETTLE_CYCLES) @(negedge clk);
        if (blur_expected.size() != 0)
        begin
            $error("%0d expected results never arrived", blur_expected.size());
            err_count++;
        end

        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
